// ===== hdl/tmd_pkg.sv =====
// Package for the thruster mixer with group desaturation.
// Holds payload structs, fixed widths and pipeline types; no dependencies.
`default_nettype none
package tmd_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;
  localparam int AXIS_W     = DATA_WIDTH + 2;   // clamped axis plus correction
  localparam int SUM_W      = DATA_WIDTH + 2;   // three-term mix sum
  localparam int MAG_W      = SUM_W - 1;        // magnitude of a mix sum
  localparam int REM_W      = MAG_W + 1;        // remainder stays below 2*m
  localparam int QUO_W      = FRAC_BITS + 1;    // quotient is at most ONE
  localparam int LANES      = 8;

  localparam logic signed [AXIS_W-1:0] ONE_AXIS = AXIS_W'(1) <<< FRAC_BITS;
  localparam logic [MAG_W-1:0]         ONE_MAG  = MAG_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] forward_cmd;
    logic signed [DATA_WIDTH-1:0] strafe_cmd;
    logic signed [DATA_WIDTH-1:0] yaw_cmd;
    logic signed [DATA_WIDTH-1:0] vertical_cmd;
    logic signed [DATA_WIDTH-1:0] pitch_cmd;
    logic signed [DATA_WIDTH-1:0] roll_cmd;
    logic signed [DATA_WIDTH-1:0] yaw_correction;
    logic signed [DATA_WIDTH-1:0] pitch_correction;
    logic signed [DATA_WIDTH-1:0] roll_correction;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] front_left_h;
    logic signed [DATA_WIDTH-1:0] front_right_h;
    logic signed [DATA_WIDTH-1:0] rear_left_h;
    logic signed [DATA_WIDTH-1:0] rear_right_h;
    logic signed [DATA_WIDTH-1:0] left_v_a;
    logic signed [DATA_WIDTH-1:0] right_v_a;
    logic signed [DATA_WIDTH-1:0] left_v_b;
    logic signed [DATA_WIDTH-1:0] right_v_b;
  } out_item_t;

  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic             neg;
    logic             lsb;    // low magnitude bit, shifted in at the first step
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic [MAG_W-1:0] m;
    logic             pass;   // group already within range
  } grp_t;

  typedef struct packed {
    lane_t [LANES-1:0] lane;
    grp_t  [1:0]       grp;
  } div_pipe_t;

endpackage
`default_nettype wire

// ===== hdl/thruster_mix_desaturate.sv =====
// Top level of the eight-thruster mixer with per-group desaturation.
// Depends on tmd_pkg, tmd_mix, tmd_prep and tmd_div_stage.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one command set
//   (six Q1.14 commands, three PID corrections). Output channel out_valid /
//   out_stall / out_data carries the eight normalized thrusts. An item moves
//   at a clock edge where valid is high and stall is low.
// Throughput: one item per cycle while out_stall is not holding the output.
// Pipeline from input to output register: two mixing stages, one
//   magnitude/maximum stage, fifteen restoring-division stages (one quotient
//   bit each, eight lanes side by side) and the output register.
// The whole pipeline advances together. While out_valid is high and
//   out_stall is asserted every stage holds and in_stall is raised, so no
//   item is lost or repeated; bubbles move forward whenever the output is
//   free.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are
//   not reset. The block keeps no state between items.
`default_nettype none
module thruster_mix_desaturate
  import tmd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int STEPS = QUO_W;

  logic             en;
  logic             mix_valid;
  sum_t [LANES-1:0] mix_sum;
  logic             sv [STEPS+1];
  div_pipe_t        sd [STEPS+1];
  logic             out_valid_r;
  out_item_t        out_data_r;
  logic [DATA_WIDTH-1:0] res [LANES];

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  tmd_mix u_mix (
    .clk, .rst_n, .en, .in_valid, .in_data, .mix_valid, .mix_sum
  );

  tmd_prep u_prep (
    .clk, .rst_n, .en, .mix_valid, .mix_sum,
    .prep_valid (sv[0]),
    .prep_data  (sd[0])
  );

  for (genvar k = 0; k < STEPS; k++) begin : g_div
    tmd_div_stage #(.FIRST(k == 0)) u_step (
      .clk, .rst_n, .en,
      .d_valid (sv[k]),
      .d_data  (sd[k]),
      .q_valid (sv[k+1]),
      .q_data  (sd[k+1])
    );
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      res[i] = sd[STEPS].lane[i].neg ? DATA_WIDTH'(-{1'b0, sd[STEPS].lane[i].quo})
                                     : DATA_WIDTH'({1'b0, sd[STEPS].lane[i].quo});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sv[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.front_left_h  <= res[0];
      out_data_r.front_right_h <= res[1];
      out_data_r.rear_left_h   <= res[2];
      out_data_r.rear_right_h  <= res[3];
      out_data_r.left_v_a      <= res[4];
      out_data_r.right_v_a     <= res[5];
      out_data_r.left_v_b      <= res[6];
      out_data_r.right_v_b     <= res[7];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== hdl/tmd_mix.sv =====
// Clamp, correction add and mixing: two register stages.
// Depends on tmd_pkg.
`default_nettype none
module tmd_mix
  import tmd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     en,
  input  wire logic     in_valid,
  input  wire in_item_t in_data,
  output logic          mix_valid,
  output sum_t [LANES-1:0] mix_sum
);

  function automatic logic signed [AXIS_W-1:0] sat_unit(input logic signed [DATA_WIDTH-1:0] x);
    logic signed [AXIS_W-1:0] w;
    w = AXIS_W'(x);
    if (w > ONE_AXIS) return ONE_AXIS;
    if (w < -ONE_AXIS) return -ONE_AXIS;
    return w;
  endfunction

  logic signed [AXIS_W-1:0] f_r, s_r, y_r, v_r, p_r, r_r;
  logic                     v1_r, v2_r;
  sum_t [LANES-1:0]         sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_r <= sat_unit(in_data.forward_cmd);
      s_r <= sat_unit(in_data.strafe_cmd);
      v_r <= sat_unit(in_data.vertical_cmd);
      y_r <= sat_unit(in_data.yaw_cmd) + AXIS_W'(in_data.yaw_correction);
      p_r <= sat_unit(in_data.pitch_cmd) + AXIS_W'(in_data.pitch_correction);
      r_r <= sat_unit(in_data.roll_cmd) + AXIS_W'(in_data.roll_correction);
      sum_r[0] <= SUM_W'(f_r - s_r + y_r);
      sum_r[1] <= SUM_W'(f_r - s_r - y_r);
      sum_r[2] <= SUM_W'(f_r + s_r + y_r);
      sum_r[3] <= SUM_W'(f_r + s_r - y_r);
      sum_r[4] <= SUM_W'(v_r + p_r + r_r);
      sum_r[5] <= SUM_W'(v_r + p_r - r_r);
      sum_r[6] <= SUM_W'(v_r - p_r + r_r);
      sum_r[7] <= SUM_W'(v_r - p_r - r_r);
    end
  end

  assign mix_valid = v2_r;
  assign mix_sum   = sum_r;

endmodule
`default_nettype wire

// ===== hdl/tmd_prep.sv =====
// Magnitude and group maximum; seeds the divider lanes.
// Depends on tmd_pkg.
`default_nettype none
module tmd_prep
  import tmd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  mix_valid,
  input  wire sum_t [LANES-1:0] mix_sum,
  output logic       prep_valid,
  output div_pipe_t  prep_data
);

  logic [MAG_W-1:0] mag [LANES];
  logic [MAG_W-1:0] mx  [2];
  div_pipe_t        nxt;
  logic             valid_r;
  div_pipe_t        data_r;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      mag[i] = mix_sum[i][SUM_W-1] ? MAG_W'(-mix_sum[i]) : MAG_W'(mix_sum[i]);
    end
    for (int g = 0; g < 2; g++) begin
      mx[g] = mag[4*g];
      for (int k = 1; k < 4; k++) begin
        if (mag[4*g+k] > mx[g]) mx[g] = mag[4*g+k];
      end
      nxt.grp[g].m    = mx[g];
      nxt.grp[g].pass = (mx[g] <= ONE_MAG);
    end
    for (int i = 0; i < LANES; i++) begin
      nxt.lane[i].neg = mix_sum[i][SUM_W-1];
      nxt.lane[i].lsb = mag[i][0];
      // in-range groups skip the division: magnitude goes straight to the quotient
      if (mx[i/4] <= ONE_MAG) begin
        nxt.lane[i].rem = '0;
        nxt.lane[i].quo = QUO_W'(mag[i]);
      end else begin
        nxt.lane[i].rem = REM_W'(mag[i] >> 1);
        nxt.lane[i].quo = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= mix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) data_r <= nxt;
  end

  assign prep_valid = valid_r;
  assign prep_data  = data_r;

endmodule
`default_nettype wire

// ===== hdl/tmd_div_stage.sv =====
// One restoring-division step for all eight lanes, registered.
// Depends on tmd_pkg.
`default_nettype none
module tmd_div_stage
  import tmd_pkg::*;
#(
  parameter bit FIRST = 1'b0
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire logic      d_valid,
  input  wire div_pipe_t d_data,
  output logic           q_valid,
  output div_pipe_t      q_data
);

  div_pipe_t        nxt;
  logic [REM_W-1:0] sh;
  logic [MAG_W-1:0] m;
  logic             valid_r;
  div_pipe_t        data_r;

  always_comb begin
    nxt = d_data;
    sh  = '0;
    m   = '0;
    for (int i = 0; i < LANES; i++) begin
      m  = d_data.grp[i/4].m;
      // dividend is mag << FRAC_BITS: only the first step brings in a nonzero bit
      sh = {d_data.lane[i].rem[REM_W-2:0], FIRST ? d_data.lane[i].lsb : 1'b0};
      if (!d_data.grp[i/4].pass) begin
        if (sh >= REM_W'(m)) begin
          nxt.lane[i].rem = sh - REM_W'(m);
          nxt.lane[i].quo = {d_data.lane[i].quo[QUO_W-2:0], 1'b1};
        end else begin
          nxt.lane[i].rem = sh;
          nxt.lane[i].quo = {d_data.lane[i].quo[QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) data_r <= nxt;
  end

  assign q_valid = valid_r;
  assign q_data  = data_r;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for thruster_mix_desaturate: drives random and directed command sets,
// predicts the eight normalized thrusts in the testbench and compares each result.
// Depends on tmd_pkg and the thruster_mix_desaturate RTL.
`timescale 1ns / 100ps
module testbench;
  import tmd_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LATENCY        = 19;
  localparam longint ONE_Q      = 64'sd1 << FRAC_BITS;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  out_item_t thrust_queue[$];
  int        error_count = 0;
  int        idle_cycles = 0;
  bit        random_stall = 1'b0;
  bit        hold_output = 1'b0;

  always #4 clk = ~clk;

  thruster_mix_desaturate u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  function automatic longint clamp_unit(logic signed [DATA_WIDTH-1:0] x);
    longint v;
    v = x;
    if (v > ONE_Q) return ONE_Q;
    if (v < -ONE_Q) return -ONE_Q;
    return v;
  endfunction

  function automatic void desaturate(ref longint g[4]);
    longint m;
    m = 0;
    for (int i = 0; i < 4; i++) begin
      if ((g[i] < 0 ? -g[i] : g[i]) > m) m = (g[i] < 0 ? -g[i] : g[i]);
    end
    if (m > ONE_Q) begin
      for (int i = 0; i < 4; i++) g[i] = (g[i] * ONE_Q) / m;
    end
  endfunction

  function automatic out_item_t mix_thrusts(in_item_t c);
    longint f, s, y, v, p, r;
    longint h[4];
    longint w[4];
    out_item_t o;
    f = clamp_unit(c.forward_cmd);
    s = clamp_unit(c.strafe_cmd);
    y = clamp_unit(c.yaw_cmd) + longint'(c.yaw_correction);
    v = clamp_unit(c.vertical_cmd);
    p = clamp_unit(c.pitch_cmd) + longint'(c.pitch_correction);
    r = clamp_unit(c.roll_cmd) + longint'(c.roll_correction);
    h[0] = f - s + y; h[1] = f - s - y; h[2] = f + s + y; h[3] = f + s - y;
    w[0] = v + p + r; w[1] = v + p - r; w[2] = v - p + r; w[3] = v - p - r;
    desaturate(h);
    desaturate(w);
    o.front_left_h  = h[0][DATA_WIDTH-1:0];
    o.front_right_h = h[1][DATA_WIDTH-1:0];
    o.rear_left_h   = h[2][DATA_WIDTH-1:0];
    o.rear_right_h  = h[3][DATA_WIDTH-1:0];
    o.left_v_a      = w[0][DATA_WIDTH-1:0];
    o.right_v_a     = w[1][DATA_WIDTH-1:0];
    o.left_v_b      = w[2][DATA_WIDTH-1:0];
    o.right_v_b     = w[3][DATA_WIDTH-1:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // Result checker
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (thrust_queue.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        e = thrust_queue.pop_front();
        if (out_data.front_left_h !== e.front_left_h)
          report_mismatch("front_left_h", out_data.front_left_h, e.front_left_h);
        if (out_data.front_right_h !== e.front_right_h)
          report_mismatch("front_right_h", out_data.front_right_h, e.front_right_h);
        if (out_data.rear_left_h !== e.rear_left_h)
          report_mismatch("rear_left_h", out_data.rear_left_h, e.rear_left_h);
        if (out_data.rear_right_h !== e.rear_right_h)
          report_mismatch("rear_right_h", out_data.rear_right_h, e.rear_right_h);
        if (out_data.left_v_a !== e.left_v_a)
          report_mismatch("left_v_a", out_data.left_v_a, e.left_v_a);
        if (out_data.right_v_a !== e.right_v_a)
          report_mismatch("right_v_a", out_data.right_v_a, e.right_v_a);
        if (out_data.left_v_b !== e.left_v_b)
          report_mismatch("left_v_b", out_data.left_v_b, e.left_v_b);
        if (out_data.right_v_b !== e.right_v_b)
          report_mismatch("right_v_b", out_data.right_v_b, e.right_v_b);
      end
    end
  end

  // Receiver: per-item random wait, or a long hold-off when asked
  initial begin
    int wait_left;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (hold_output) begin
        out_stall <= 1'b1;
      end else if (wait_left > 0) begin
        wait_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (out_valid && !out_stall && random_stall) wait_left = $urandom_range(0, 12);
      end
    end
  end

  // Watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Drop valid only for a gap, so a back-to-back item keeps it high
  task automatic send_item(in_item_t c, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= c;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    thrust_queue.push_back(mix_thrusts(c));
  endtask

  function automatic logic [15:0] rand_field(int mode);
    case (mode)
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($signed($urandom_range(0, 32768)) - 16384);
      2: return 16'($signed($urandom_range(0, 8192)) - 4096);
      default: begin
        case ($urandom_range(0, 5))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h4000;
          3: return 16'hc000;
          4: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t c;
    int mode;
    mode = $urandom_range(0, 3);
    c.forward_cmd      = rand_field(mode);
    c.strafe_cmd       = rand_field(mode);
    c.yaw_cmd          = rand_field(mode);
    c.vertical_cmd     = rand_field(mode);
    c.pitch_cmd        = rand_field(mode);
    c.roll_cmd         = rand_field(mode);
    c.yaw_correction   = rand_field($urandom_range(0, 3));
    c.pitch_correction = rand_field($urandom_range(0, 3));
    c.roll_correction  = rand_field($urandom_range(0, 3));
    return c;
  endfunction

  task automatic test_directed();
    in_item_t c;
    c = '0;
    send_item(c, 0);
    c = {9{16'h7fff}};
    send_item(c, 0);
    c = {9{16'h8000}};
    send_item(c, 1);
    // within range: no division
    c = '0; c.forward_cmd = 16'd4000; c.strafe_cmd = 16'd2000; c.yaw_cmd = 16'd1000;
    c.vertical_cmd = -16'sd3000; c.pitch_cmd = 16'd500; c.roll_cmd = -16'sd700;
    send_item(c, 0);
    // exactly one in magnitude
    c = '0; c.forward_cmd = 16'h4000; c.vertical_cmd = 16'hc000;
    send_item(c, 0);
    // saturated commands, one group over range
    c = '0; c.forward_cmd = 16'h7fff; c.strafe_cmd = 16'h8000; c.yaw_cmd = 16'h4000;
    send_item(c, 2);
    c = '0; c.yaw_correction = 16'h7fff; c.pitch_correction = 16'h8000;
    c.roll_correction = 16'h7fff;
    send_item(c, 0);
    c = '0; c.pitch_cmd = 16'h4001; c.roll_cmd = 16'hbfff; c.vertical_cmd = 16'h4000;
    send_item(c, 0);
    for (int i = 0; i < 12; i++) send_item(rand_item(), 0);
  endtask

  task automatic test_random(int count);
    random_stall = 1'b1;
    for (int i = 0; i < count; i++)
      send_item(rand_item(), ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12));
  endtask

  task automatic test_backpressure();
    random_stall = 1'b0;
    fork
      begin
        hold_output = 1'b1;
        repeat (200) @(posedge clk);
        hold_output = 1'b0;
      end
      for (int i = 0; i < 60; i++) send_item(rand_item(), 0);
    join
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(350);
    test_backpressure();
    test_random(330);
    in_valid <= 1'b0;
    random_stall = 1'b0;
    while (thrust_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (error_count == 0 && thrust_queue.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
